// ===== design/bdeq_pkg.sv =====
// Shared types, codes and constants for the bounded double-ended queue.
package bdeq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned MAX_RESULTS   = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_DUMP       = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_CLEAR      = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item;
    status_t            status;
    logic               last;
  } rsp_t;

  typedef enum logic [2:0] {
    RING_NOP,
    RING_PUSH_FRONT,
    RING_PUSH_BACK,
    RING_POP_FRONT,
    RING_POP_BACK,
    RING_READ,
    RING_CLEAR
  } ring_op_t;

  typedef struct packed {
    ring_op_t           op;
    logic signed [31:0] wdata;
  } ring_cmd_t;

endpackage

// ===== design/bdeq_ring.sv =====
// Ring store with front index, occupancy count and a registered read port.
module bdeq_ring import bdeq_pkg::*; #(
  parameter  int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  ring_cmd_t          cmd,
  input  logic [IW-1:0]      offset,
  output logic [CW-1:0]      occupancy,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];
  logic [IW-1:0]      front;
  logic [IW-1:0]      occ_lo;
  logic [IW-1:0]      prev_front;
  logic [IW-1:0]      next_front;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;

  // Adds two in-range indexes modulo DEPTH; the sum stays below twice DEPTH.
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign occ_lo     = occupancy[IW-1:0];
  assign prev_front = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign next_front = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front;
    rd_en   = 1'b0;
    rd_addr = front;
    unique case (cmd.op)
      RING_PUSH_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = prev_front;
      end
      RING_PUSH_BACK: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(front, occ_lo);
      end
      RING_POP_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = front;
      end
      RING_POP_BACK: begin
        rd_en   = 1'b1;
        rd_addr = wrap_add(front, occ_lo - 1'b1);
      end
      RING_READ: begin
        rd_en   = 1'b1;
        rd_addr = wrap_add(front, offset);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      occupancy <= '0;
    end else begin
      unique case (cmd.op)
        RING_PUSH_FRONT: begin
          front     <= prev_front;
          occupancy <= occupancy + 1'b1;
        end
        RING_PUSH_BACK: begin
          occupancy <= occupancy + 1'b1;
        end
        RING_POP_FRONT: begin
          front     <= next_front;
          occupancy <= occupancy - 1'b1;
        end
        RING_POP_BACK: begin
          occupancy <= occupancy - 1'b1;
        end
        RING_CLEAR: begin
          front     <= '0;
          occupancy <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue: transaction control and result register.
//
//   channel | signals                          | payload
//   --------+----------------------------------+--------------------------------
//   request | req_valid, req_ready, req        | func, value
//   result  | rsp_valid, rsp_ready, rsp        | item, status, last
//
// A push, a rejected push or an empty status registers its result when it is taken;
// an unknown code is taken with no result. A pop passes the ring's registered read
// port and S_POP. Dump and clear read each reported entry through S_REQ and S_WAIT,
// held in S_WAIT by result stalls; the request side is held off until the last result
// of the run is registered. A request is taken while the previous result still waits,
// as long as the result register empties in that cycle. Reset empties the queue at once.
module bounded_double_ended_queue import bdeq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned RunMax = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_REQ,
    S_WAIT
  } state_t;

  state_t             state;
  logic [CW-1:0]      k;
  logic [CW-1:0]      n_run;
  logic               is_clear;
  logic               rsp_free;
  logic               accept;
  logic               full;
  logic               empty;
  logic               run_last;
  logic [CW-1:0]      run_len;
  logic [CW-1:0]      occupancy;
  logic signed [31:0] rdata;
  ring_cmd_t          cmd;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign accept    = req_valid && req_ready;
  assign full      = (occupancy == CW'(DEPTH));
  assign empty     = (occupancy == '0);
  assign run_last  = (k + 1'b1 == n_run);
  assign run_len   = (occupancy > CW'(RunMax)) ? CW'(RunMax) : occupancy;

  always_comb begin
    cmd.op    = RING_NOP;
    cmd.wdata = req.value;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FN_PUSH_FRONT: if (!full)  cmd.op = RING_PUSH_FRONT;
            FN_PUSH_BACK:  if (!full)  cmd.op = RING_PUSH_BACK;
            FN_POP_FRONT:  if (!empty) cmd.op = RING_POP_FRONT;
            FN_POP_BACK:   if (!empty) cmd.op = RING_POP_BACK;
            default: begin
            end
          endcase
        end
      end
      S_REQ: begin
        cmd.op = RING_READ;
      end
      S_WAIT: begin
        if (rsp_free && run_last && is_clear) begin
          cmd.op = RING_CLEAR;
        end
      end
      default: begin
      end
    endcase
  end

  bdeq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .offset    (k[IW-1:0]),
    .occupancy (occupancy),
    .rdata     (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      k         <= '0;
      n_run     <= '0;
      is_clear  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.func)
              FN_PUSH_FRONT, FN_PUSH_BACK: begin
                rsp_valid  <= 1'b1;
                rsp.item   <= '0;
                rsp.status <= full ? STAT_FULL : STAT_OK;
                rsp.last   <= 1'b1;
              end
              FN_POP_FRONT, FN_POP_BACK: begin
                if (empty) begin
                  rsp_valid  <= 1'b1;
                  rsp.item   <= '0;
                  rsp.status <= STAT_EMPTY;
                  rsp.last   <= 1'b1;
                end else begin
                  state <= S_POP;
                end
              end
              FN_DUMP, FN_CLEAR: begin
                if (empty) begin
                  rsp_valid  <= 1'b1;
                  rsp.item   <= '0;
                  rsp.status <= STAT_EMPTY;
                  rsp.last   <= 1'b1;
                end else begin
                  k        <= '0;
                  n_run    <= run_len;
                  is_clear <= (req.func == FN_CLEAR);
                  state    <= S_REQ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          // The result register was emptied when the pop was taken.
          rsp_valid  <= 1'b1;
          rsp.item   <= rdata;
          rsp.status <= STAT_OK;
          rsp.last   <= 1'b1;
          state      <= S_IDLE;
        end
        S_REQ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          // Read data holds while the result register is still occupied.
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            rsp.item   <= rdata;
            rsp.status <= STAT_OK;
            rsp.last   <= run_last;
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_REQ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy exceeds the queue depth");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> rsp_valid && rsp.last && rsp.status == STAT_OK)
    else $error("pop did not produce its result");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && rsp_free && run_last |=> state == S_IDLE && rsp_valid && rsp.last)
    else $error("run did not end on its last entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.op == RING_CLEAR |=> occupancy == '0)
    else $error("clear left entries in the queue");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STAT_OK |-> rsp.last && rsp.item == '0)
    else $error("status result is not a single zero result");

endmodule
